// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the checker files.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/wardet_pkg.sv =====
// ----------------------------------------------------------------------------
// wardet_pkg
// Types and codes shared by the write-after-read detector modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wardet_pkg;

	localparam int ADDR_W = 32;
	localparam int DATA_W = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE_BASE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE_LENGTH = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data_value;
		logic [ADDR_W-1:0] instr_pc;
	} item_t;

	typedef struct packed {
		logic              war_found;
		logic              skipped;
		logic              table_full;
		logic [ADDR_W-1:0] conflict_address;
		logic [ADDR_W-1:0] read_pc_out;
		logic [DATA_W-1:0] read_value_out;
		logic [ADDR_W-1:0] write_pc_out;
		logic [DATA_W-1:0] write_value_out;
	} result_t;

	typedef struct packed {
		logic insert;
		logic clear;
	} set_ctrl_t;

	typedef struct packed {
		logic hit;
		logic full;
	} set_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/wardet_tag_cam.sv =====
// ----------------------------------------------------------------------------
// wardet_tag_cam
// Address set held in flip-flops, with a parallel compare on every entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wardet_tag_cam #(
	parameter int ENTRIES = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire wardet_pkg::set_ctrl_t              ctrl,
	input  wire logic [wardet_pkg::ADDR_W-1:0]      lookup_address,
	output wardet_pkg::set_stat_t                   stat,
	output logic [$clog2(ENTRIES)-1:0]              hit_index,
	output logic [$clog2(ENTRIES)-1:0]              free_index
);

	localparam int IDX_W = $clog2(ENTRIES);

	logic [ENTRIES-1:0]                 valid_q;
	logic [wardet_pkg::ADDR_W-1:0]      tag_q [ENTRIES];
	logic [ENTRIES-1:0]                 match;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (tag_q[i] == lookup_address);
		end
	end

	// Entries are never duplicated, so at most one match bit is set and an
	// OR of the matching indexes gives the hit position.
	always_comb begin
		hit_index = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_index = hit_index | IDX_W'(i);
			end
		end
	end

	always_comb begin
		free_index = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_index = IDX_W'(i);
			end
		end
	end

	assign stat.hit  = |match;
	assign stat.full = &valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.clear) begin
			valid_q <= '0;
		end else if (ctrl.insert) begin
			valid_q[free_index] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			tag_q[free_index] <= lookup_address;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/wardet_read_set.sv =====
// ----------------------------------------------------------------------------
// wardet_read_set
// Read address set with a memory holding the first pc and value per entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wardet_read_set #(
	parameter int ENTRIES = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire wardet_pkg::set_ctrl_t              ctrl,
	input  wire logic                               advance,
	input  wire logic [wardet_pkg::ADDR_W-1:0]      lookup_address,
	input  wire logic [wardet_pkg::DATA_W-1:0]      insert_value,
	input  wire logic [wardet_pkg::ADDR_W-1:0]      insert_pc,
	output wardet_pkg::set_stat_t                   stat,
	output logic [wardet_pkg::ADDR_W-1:0]           read_pc,
	output logic [wardet_pkg::DATA_W-1:0]           read_value
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int WORD_W = wardet_pkg::ADDR_W + wardet_pkg::DATA_W;

	logic [IDX_W-1:0]  hit_index;
	logic [IDX_W-1:0]  free_index;
	logic [WORD_W-1:0] info_mem [ENTRIES];
	logic [WORD_W-1:0] info_s2;

	wardet_tag_cam #(
		.ENTRIES (ENTRIES)
	) u_cam (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.lookup_address (lookup_address),
		.stat           (stat),
		.hit_index      (hit_index),
		.free_index     (free_index)
	);

	// The entry written by one request is visible to the next, as the read
	// of the following cycle comes after this write edge.
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			info_mem[free_index] <= {insert_pc, insert_value};
		end
		if (advance) begin
			info_s2 <= info_mem[hit_index];
		end
	end

	assign read_pc    = info_s2[WORD_W-1:wardet_pkg::DATA_W];
	assign read_value = info_s2[wardet_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/write_after_read_detector.sv =====
// ----------------------------------------------------------------------------
// write_after_read_detector
// Flags writes to addresses that were read before they were first written, since the last reset or clear.
// ----------------------------------------------------------------------------
// Requests arrive on item (valid/ready) and each gives exactly one result on
// result (valid/ready). A request is registered on acceptance; from the input
// register both address sets are searched in parallel, and when the request
// advances the sets are updated and the result is registered. One request
// can be taken every cycle while the receiver does not stall; the rate is
// set by the single compare-and-update pass over the flip-flop tag arrays.
// When the receiver stalls, the result register holds and the request in the
// input register waits; item_ready drops only when both are occupied.
// Reset empties both sets and the pipeline and restores the ignored range to
// enabled, zero length. The user must write the range registers (cfg_we,
// cfg_index, cfg_data) only with no request in flight; the block relies on that.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module write_after_read_detector #(
	parameter int READ_ENTRIES  = 64,
	parameter int WRITE_ENTRIES = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   item_valid,
	output logic                                        item_ready,
	input  wire wardet_pkg::item_t                      item,
	output logic                                        result_valid,
	input  wire logic                                   result_ready,
	output wardet_pkg::result_t                         result,
	input  wire logic                                   cfg_we,
	input  wire logic [wardet_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [wardet_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic                              ignore_enable_q;
	logic [wardet_pkg::ADDR_W-1:0]     ignore_base_q;
	logic [wardet_pkg::ADDR_W-1:0]     ignore_length_q;

	logic                              valid_s1;
	wardet_pkg::item_t                 item_s1;
	logic                              advance;

	wardet_pkg::set_stat_t             rstat;
	wardet_pkg::set_stat_t             wstat;
	wardet_pkg::set_ctrl_t             rctrl;
	wardet_pkg::set_ctrl_t             wctrl;
	logic [wardet_pkg::ADDR_W-1:0]     read_pc;
	logic [wardet_pkg::DATA_W-1:0]     read_value;

	logic                              in_range;
	logic                              skip_d;
	logic                              war_d;
	logic                              full_d;
	logic                              rd_insert;
	logic                              wr_insert;
	logic                              clear_d;

	logic                              valid_s2;
	logic                              war_s2;
	logic                              skip_s2;
	logic                              full_s2;
	logic [wardet_pkg::ADDR_W-1:0]     address_s2;
	logic [wardet_pkg::ADDR_W-1:0]     wpc_s2;
	logic [wardet_pkg::DATA_W-1:0]     wvalue_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_enable_q <= 1'b1;
			ignore_base_q   <= '0;
			ignore_length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wardet_pkg::CFG_IGNORE_ENABLE: ignore_enable_q <= cfg_data[0];
				wardet_pkg::CFG_IGNORE_BASE:   ignore_base_q   <= cfg_data;
				wardet_pkg::CFG_IGNORE_LENGTH: ignore_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// The end of the range is formed on 33 bits so that it cannot wrap.
	assign in_range = ignore_enable_q && (item_s1.address >= ignore_base_q) &&
		({1'b0, item_s1.address} < ({1'b0, ignore_base_q} + {1'b0, ignore_length_q}));

	always_comb begin
		skip_d    = 1'b0;
		war_d     = 1'b0;
		full_d    = 1'b0;
		rd_insert = 1'b0;
		wr_insert = 1'b0;
		clear_d   = 1'b0;
		case (item_s1.op)
			wardet_pkg::OP_READ: begin
				if (in_range) begin
					skip_d = 1'b1;
				end else if (!rstat.hit) begin
					if (rstat.full) begin
						full_d = 1'b1;
					end else begin
						rd_insert = 1'b1;
					end
				end
			end
			wardet_pkg::OP_WRITE: begin
				if (in_range) begin
					skip_d = 1'b1;
				end else if (!wstat.hit) begin
					if (rstat.hit) begin
						war_d = 1'b1;
					end else if (wstat.full) begin
						full_d = 1'b1;
					end else begin
						wr_insert = 1'b1;
					end
				end
			end
			wardet_pkg::OP_CLEAR: clear_d = 1'b1;
			default: begin
			end
		endcase
	end

	assign rctrl.insert = advance && rd_insert;
	assign rctrl.clear  = advance && clear_d;
	assign wctrl.insert = advance && wr_insert;
	assign wctrl.clear  = advance && clear_d;

	wardet_read_set #(
		.ENTRIES (READ_ENTRIES)
	) u_read_set (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (rctrl),
		.advance        (advance),
		.lookup_address (item_s1.address),
		.insert_value   (item_s1.data_value),
		.insert_pc      (item_s1.instr_pc),
		.stat           (rstat),
		.read_pc        (read_pc),
		.read_value     (read_value)
	);

	logic [$clog2(WRITE_ENTRIES)-1:0] w_hit_index;
	logic [$clog2(WRITE_ENTRIES)-1:0] w_free_index;

	wardet_tag_cam #(
		.ENTRIES (WRITE_ENTRIES)
	) u_write_set (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (wctrl),
		.lookup_address (item_s1.address),
		.stat           (wstat),
		.hit_index      (w_hit_index),
		.free_index     (w_free_index)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			war_s2     <= war_d;
			skip_s2    <= skip_d;
			full_s2    <= full_d;
			address_s2 <= war_d ? item_s1.address : '0;
			wpc_s2     <= war_d ? item_s1.instr_pc : '0;
			wvalue_s2  <= war_d ? item_s1.data_value : '0;
		end
	end

	assign result_valid             = valid_s2;
	assign result.war_found         = war_s2;
	assign result.skipped           = skip_s2;
	assign result.table_full        = full_s2;
	assign result.conflict_address  = address_s2;
	assign result.read_pc_out       = war_s2 ? read_pc : '0;
	assign result.read_value_out    = war_s2 ? read_value : '0;
	assign result.write_pc_out      = wpc_s2;
	assign result.write_value_out   = wvalue_s2;

	// The detector never needs the write set's matching position or free slot,
	// only its hit and full flags; both indexes are folded in here to keep the ports used.
	logic unused_w_hit;
	assign unused_w_hit = ^w_hit_index && ^w_free_index;

endmodule

`default_nettype wire

// ===== rtl/core/wardet_checker.sv =====
// ----------------------------------------------------------------------------
// wardet_checker
// Port-level checks on the write-after-read detector, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wardet_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                item_valid,
	input wire logic                                item_ready,
	input wire wardet_pkg::item_t                   item,
	input wire logic                                result_valid,
	input wire logic                                result_ready,
	input wire wardet_pkg::result_t                 result,
	input wire logic                                cfg_we,
	input wire logic [wardet_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input wire logic [wardet_pkg::CFG_DATA_W-1:0]   cfg_data
);

	`ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid)
	`ASSERT_NEXT(a_result_stable, clk, arst_n, result_valid && !result_ready, $stable(result))
	`ASSERT_IMPLY(a_one_flag, clk, arst_n, result_valid, $countones({result.war_found, result.skipped, result.table_full}) <= 1)
	`ASSERT_IMPLY(a_clean_fields, clk, arst_n, result_valid && !result.war_found, (result.conflict_address == '0) && (result.read_pc_out == '0) && (result.read_value_out == '0) && (result.write_pc_out == '0) && (result.write_value_out == '0))

	// Inputs that no check looks at are folded together to keep them used.
	logic unused_inputs;
	assign unused_inputs = item_valid ^ item_ready ^ (^item) ^ cfg_we ^ (^cfg_index) ^ (^cfg_data);

endmodule

bind write_after_read_detector wardet_checker u_wardet_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data)
);

`default_nettype wire
